// File: src/namt_pkg.sv
// Shared types, codes and constants for the nearest angular match table.
package namt_pkg;

   // Field widths
   localparam int ACTION_W = 2;
   localparam int ETA_W    = 14;
   localparam int PHI_W    = 13;
   localparam int PID_W    = 25;
   localparam int ID_W     = 24;
   localparam int THR_W    = 27;
   localparam int IDX_W    = 6;
   localparam int DIST_W   = 27;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   // Internal arithmetic widths
   localparam int DE_W    = ETA_W + 1;       // eta difference
   localparam int DP_W    = PHI_W + 1;       // phi difference
   localparam int DESQ_W  = 2 * ETA_W;       // |de| < 2^14
   localparam int DPSQ_W  = 2 * PHI_W;       // |dp| < 2^13
   localparam int SUM_W   = DESQ_W + 1;

   // Default table depth
   localparam int TABLE_DEPTH_DEF = 64;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

   // Register indexes
   localparam logic REG_TARGET = 1'b0;
   localparam logic REG_THRESH = 1'b1;

   // Register reset values
   localparam logic [ID_W-1:0]  TARGET_RESET = 24'd211;
   localparam logic [THR_W-1:0] THRESH_RESET = 27'd10486;

   // Angle constants, units of 2^-10 rad
   localparam logic signed [DP_W-1:0] PI_UNITS   = 14'sd3217;
   localparam logic signed [DP_W-1:0] TURN_UNITS = 14'sd6434;

   // Largest reportable distance
   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   // One stored reference entry
   typedef struct packed {
      logic signed [ETA_W-1:0] eta;
      logic signed [PHI_W-1:0] phi;
      logic [ID_W-1:0]         abs_id;
   } namt_entry_type;

   // Control tag that travels with each entry through the distance unit
   typedef struct packed {
      logic vld;
      logic elig;
   } namt_tag_type;

endpackage

// File: src/namt_dist.sv
// Pipelined squared angular distance unit, shared by every entry of a scan.
module namt_dist
   import namt_pkg::*;
#(
   parameter int AW = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  logic [AW-1:0]           in_idx,
   input  namt_entry_type          in_entry,
   input  logic signed [ETA_W-1:0] q_eta,
   input  logic signed [PHI_W-1:0] q_phi,
   input  logic [ID_W-1:0]         target_id,
   output namt_tag_type            out_tag,
   output logic [AW-1:0]           out_idx,
   output logic [SUM_W-1:0]        out_dist,
   output logic                    busy
);

   // Stage 1: differences, phi wrap, id check
   namt_tag_type             s1_tag_ff, s1_tag_in;
   logic [AW-1:0]            s1_idx_ff;
   logic signed [DE_W-1:0]   s1_de_ff, s1_de_in;
   logic signed [DP_W-1:0]   s1_dp_ff, s1_dp_in;
   logic signed [DP_W-1:0]   dp_raw;

   // Stage 2: squares
   namt_tag_type             s2_tag_ff;
   logic [AW-1:0]            s2_idx_ff;
   logic [DESQ_W-1:0]        s2_desq_ff;
   logic [DPSQ_W-1:0]        s2_dpsq_ff;
   logic signed [2*DE_W-1:0] desq_full;
   logic signed [2*DP_W-1:0] dpsq_full;

   // Stage 3: sum
   namt_tag_type             s3_tag_ff;
   logic [AW-1:0]            s3_idx_ff;
   logic [SUM_W-1:0]         s3_sum_ff;

   always_comb begin
      s1_tag_in.vld  = in_vld;
      s1_tag_in.elig = (in_entry.abs_id == target_id);
      s1_de_in = DE_W'(q_eta) - DE_W'(in_entry.eta);
      dp_raw   = DP_W'(q_phi) - DP_W'(in_entry.phi);
      // one wrap step brings dphi into [-pi, pi]
      if (dp_raw > PI_UNITS) begin
         s1_dp_in = dp_raw - TURN_UNITS;
      end else if (dp_raw < -PI_UNITS) begin
         s1_dp_in = dp_raw + TURN_UNITS;
      end else begin
         s1_dp_in = dp_raw;
      end
   end

   assign desq_full = s1_de_ff * s1_de_ff;
   assign dpsq_full = s1_dp_ff * s1_dp_ff;

   // control valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
      end else begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      s1_idx_ff  <= in_idx;
      s1_de_ff   <= s1_de_in;
      s1_dp_ff   <= s1_dp_in;
      s2_idx_ff  <= s1_idx_ff;
      s2_desq_ff <= desq_full[DESQ_W-1:0];
      s2_dpsq_ff <= dpsq_full[DPSQ_W-1:0];
      s3_idx_ff  <= s2_idx_ff;
      s3_sum_ff  <= SUM_W'(s2_desq_ff) + SUM_W'(s2_dpsq_ff);
   end

   assign out_tag  = s3_tag_ff;
   assign out_idx  = s3_idx_ff;
   assign out_dist = s3_sum_ff;
   assign busy     = s1_tag_ff.vld | s2_tag_ff.vld | s3_tag_ff.vld;

endmodule

// File: src/nearest_angular_match_table.sv
// Nearest angular match table: reference entry store, scan sequencer and result register.
// Clear and load items leave the block idle, so it stays ready for the next item.
// A query reads one entry per cycle into a three-stage distance unit; once the scan has
// drained, the result is registered when the output register is free, held back while an
// earlier result waits; the block takes no item during a query.
// Synchronous reset empties the table, clears the overflow flag and loads register defaults.
module nearest_angular_match_table
   import namt_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   // item input
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_W-1:0]     req_action,
   input  logic signed [ETA_W-1:0] req_eta,
   input  logic signed [PHI_W-1:0] req_phi,
   input  logic signed [PID_W-1:0] req_particle_id,
   // result output
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [IDX_W-1:0]        rsp_match_index,
   output logic [DIST_W-1:0]       rsp_distance_sq,
   output logic                    rsp_truncated,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [PADDR_W-1:0]      paddr,
   input  logic [PDATA_W-1:0]      pwdata,
   output logic [PDATA_W-1:0]      prdata,
   output logic                    pready
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   // Registers
   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [CW-1:0]       ptr_ff, ptr_in;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_idx_ff;
   namt_entry_type      rd_data_ff;
   logic signed [ETA_W-1:0] q_eta_ff;
   logic signed [PHI_W-1:0] q_phi_ff;
   logic                have_ff, have_in;
   logic [SUM_W-1:0]    best_ff, best_in;
   logic [AW-1:0]       best_idx_ff, best_idx_in;
   logic [ID_W-1:0]     target_ff;
   logic [THR_W-1:0]    thresh_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff;
   logic [IDX_W-1:0]    idx_out_ff;
   logic [DIST_W-1:0]   dist_out_ff;
   logic                trunc_ff;

   namt_entry_type      ref_mem [TABLE_DEPTH];

   // Handshake and decode
   logic                accept;
   logic                do_load;
   logic                do_query;
   logic                issue;
   logic                rsp_load;
   logic                cfg_wr;
   logic [PID_W-1:0]    pid_mag;
   namt_entry_type      wr_entry;
   namt_tag_type        d_tag;
   logic [AW-1:0]       d_idx;
   logic [SUM_W-1:0]    d_dist;
   logic                d_busy;
   logic [AW+IDX_W-1:0] idx_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign do_load   = accept & (req_action == ACT_LOAD);
   assign do_query  = accept & (req_action == ACT_QUERY);
   assign issue     = (state_ff == ST_SCAN) & (ptr_ff < count_ff);
   assign rsp_load  = (state_ff == ST_FIN) & (~rsp_valid_ff | rsp_ready);

   // Absolute particle id, saturated to 24 bits
   always_comb begin
      pid_mag = req_particle_id[PID_W-1] ? (~req_particle_id + PID_W'(1))
                                         : req_particle_id;
      wr_entry.eta = req_eta;
      wr_entry.phi = req_phi;
      wr_entry.abs_id = pid_mag[PID_W-1] ? {ID_W{1'b1}} : pid_mag[ID_W-1:0];
   end

   // Reference store: one write, one registered read
   always_ff @(posedge clock) begin
      if (do_load && (count_ff < CW'(TABLE_DEPTH))) begin
         ref_mem[count_ff[AW-1:0]] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= ref_mem[ptr_ff[AW-1:0]];
      rd_idx_ff  <= ptr_ff[AW-1:0];
   end

   // Distance unit
   namt_dist #(
      .AW (AW)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (rd_vld_ff),
      .in_idx    (rd_idx_ff),
      .in_entry  (rd_data_ff),
      .q_eta     (q_eta_ff),
      .q_phi     (q_phi_ff),
      .target_id (target_ff),
      .out_tag   (d_tag),
      .out_idx   (d_idx),
      .out_dist  (d_dist),
      .busy      (d_busy)
   );

   // Sequencer, table bookkeeping and running minimum
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      ptr_in       = ptr_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  ACT_LOAD: begin
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        count_in = count_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  ACT_QUERY: begin
                     ptr_in   = '0;
                     have_in  = 1'b0;
                     best_in  = '0;
                     best_idx_in = '0;
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (issue) begin
               ptr_in = ptr_ff + CW'(1);
            end
            // earlier entry wins a tie: strict less-than
            if (d_tag.vld && d_tag.elig && (!have_ff || (d_dist < best_ff))) begin
               have_in     = 1'b1;
               best_in     = d_dist;
               best_idx_in = d_idx;
            end
            if (!issue && !rd_vld_ff && !d_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ptr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ptr_ff       <= ptr_in;
         rd_vld_ff    <= issue;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Query coordinates and running minimum payload
   always_ff @(posedge clock) begin
      if (do_query) begin
         q_eta_ff <= req_eta;
         q_phi_ff <= req_phi;
      end
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   // Result register
   assign idx_ext = {{IDX_W{1'b0}}, best_idx_ff};

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         found_ff   <= have_ff & (best_ff <= SUM_W'(thresh_ff));
         idx_out_ff <= have_ff ? idx_ext[IDX_W-1:0] : '0;
         if (!have_ff) begin
            dist_out_ff <= '0;
         end else if (best_ff > SUM_W'(DIST_MAX)) begin
            dist_out_ff <= DIST_MAX;
         end else begin
            dist_out_ff <= best_ff[DIST_W-1:0];
         end
         trunc_ff <= ovf_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_match_index = idx_out_ff;
   assign rsp_distance_sq = dist_out_ff;
   assign rsp_truncated   = trunc_ff;

   // Configuration registers
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         thresh_ff <= THRESH_RESET;
      end else if (cfg_wr) begin
         unique case (paddr[2])
            REG_TARGET: target_ff <= pwdata[ID_W-1:0];
            REG_THRESH: thresh_ff <= pwdata[THR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TARGET: prdata = PDATA_W'(target_ff);
         REG_THRESH: prdata = PDATA_W'(thresh_ff);
         default:    prdata = '0;
      endcase
   end

endmodule
